// ===== rtl/c2p_pkg.sv =====
// Shared constants and the arctangent table for the cartesian-to-polar unit.
// Used by every module of the unit; depends on nothing else.
package c2p_pkg;

    localparam int ROT_W        = 14;
    localparam int ANGLE_W      = 17;
    localparam int Z_W          = 28;
    localparam int ATAN_ENTRIES = 24;
    localparam int PRESCALE_SH  = 16;
    localparam int ROT_UNIT_W   = 24;
    localparam int PROD_W       = 38;
    localparam int TOTAL_W      = 39;
    localparam int ROUND_SH     = 20;

    localparam logic signed [Z_W-1:0]        PI_Q24       = Z_W'(52707179);
    localparam logic signed [ROT_UNIT_W-1:0] ROT_UNIT_Q32 = ROT_UNIT_W'(4685083);

    typedef logic signed [Z_W-1:0] angle_acc_t;

    // atan(2^-i) in Q.24 radians, rounded to nearest.
    function automatic angle_acc_t atan_q24(input int idx);
        angle_acc_t v;
        case (idx)
            0:       v = Z_W'(13176795);
            1:       v = Z_W'(7778716);
            2:       v = Z_W'(4110060);
            3:       v = Z_W'(2086331);
            4:       v = Z_W'(1047214);
            5:       v = Z_W'(524117);
            6:       v = Z_W'(262123);
            7:       v = Z_W'(131069);
            8:       v = Z_W'(65536);
            9:       v = Z_W'(32768);
            10:      v = Z_W'(16384);
            11:      v = Z_W'(8192);
            12:      v = Z_W'(4096);
            13:      v = Z_W'(2048);
            14:      v = Z_W'(1024);
            15:      v = Z_W'(512);
            16:      v = Z_W'(256);
            17:      v = Z_W'(128);
            18:      v = Z_W'(64);
            19:      v = Z_W'(32);
            20:      v = Z_W'(16);
            21:      v = Z_W'(8);
            22:      v = Z_W'(4);
            23:      v = Z_W'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/c2p_prep.sv =====
// Entry stage: registers the request, folds the left half-plane, scales x and y
// for the CORDIC chain and forms the sum of squares. Depends on c2p_pkg.
module c2p_prep import c2p_pkg::*; #(
    parameter int W = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic signed [W-1:0]      in_x,
    input  logic signed [W-1:0]      in_y,
    input  logic signed [ROT_W-1:0]  in_rot,
    output logic                     out_valid,
    output logic signed [W+18:0]     out_cx,
    output logic signed [W+18:0]     out_cy,
    output angle_acc_t               out_z,
    output logic                     out_zero,
    output logic [2*W:0]             out_rem,
    output logic signed [ROT_W-1:0]  out_rot,
    output logic signed [W-1:0]      out_x,
    output logic signed [W-1:0]      out_y
);
    localparam int CW = W + 19;
    localparam int RW = 2 * W + 1;

    logic                    valid_reg;
    logic signed [CW-1:0]    cx_reg, cx_next;
    logic signed [CW-1:0]    cy_reg, cy_next;
    angle_acc_t              z_reg, z_next;
    logic                    zero_reg;
    logic [RW-1:0]           rem_reg, rem_next;
    logic signed [ROT_W-1:0] rot_reg;
    logic signed [W-1:0]     x_reg, y_reg;
    logic signed [CW-1:0]    xs, ys;
    logic signed [2*W-1:0]   xx, yy;

    assign xs = CW'(in_x) <<< PRESCALE_SH;
    assign ys = CW'(in_y) <<< PRESCALE_SH;
    assign xx = in_x * in_x;
    assign yy = in_y * in_y;

    always_comb begin
        // A vector in the left half-plane is turned by pi first.
        if (in_x[W-1]) begin
            cx_next = -xs;
            cy_next = -ys;
            z_next  = in_y[W-1] ? -PI_Q24 : PI_Q24;
        end else begin
            cx_next = xs;
            cy_next = ys;
            z_next  = '0;
        end
        rem_next = {1'b0, xx} + {1'b0, yy};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            z_reg    <= z_next;
            zero_reg <= (in_x == '0) && (in_y == '0);
            rem_reg  <= rem_next;
            rot_reg  <= in_rot;
            x_reg    <= in_x;
            y_reg    <= in_y;
        end
    end

    assign out_valid = valid_reg;
    assign out_cx    = cx_reg;
    assign out_cy    = cy_reg;
    assign out_z     = z_reg;
    assign out_zero  = zero_reg;
    assign out_rem   = rem_reg;
    assign out_rot   = rot_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

// ===== rtl/c2p_cell.sv =====
// One cell of the chain: a CORDIC vectoring micro-rotation if IDX < STAGES and
// ATAN_ENTRIES, a square-root digit if IDX < W; registered. Depends on c2p_pkg.
module c2p_cell import c2p_pkg::*; #(
    parameter int IDX    = 0,
    parameter int STAGES = 16,
    parameter int W      = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic signed [W+18:0]     in_cx,
    input  logic signed [W+18:0]     in_cy,
    input  angle_acc_t               in_z,
    input  logic                     in_zero,
    input  logic [2*W:0]             in_rem,
    input  logic [2*W:0]             in_root,
    input  logic signed [ROT_W-1:0]  in_rot,
    input  logic signed [W-1:0]      in_x,
    input  logic signed [W-1:0]      in_y,
    output logic                     out_valid,
    output logic signed [W+18:0]     out_cx,
    output logic signed [W+18:0]     out_cy,
    output angle_acc_t               out_z,
    output logic                     out_zero,
    output logic [2*W:0]             out_rem,
    output logic [2*W:0]             out_root,
    output logic signed [ROT_W-1:0]  out_rot,
    output logic signed [W-1:0]      out_x,
    output logic signed [W-1:0]      out_y
);
    localparam int  CW      = W + 19;
    localparam int  RW      = 2 * W + 1;
    localparam bit  DO_ROT  = (IDX < STAGES) && (IDX < ATAN_ENTRIES);
    localparam bit  DO_SQRT = (IDX < W);
    localparam int  BIT_POS = DO_SQRT ? (2 * W - 2 - 2 * IDX) : 0;
    localparam logic [RW-1:0]  SQ_BIT = RW'(1) << BIT_POS;
    localparam angle_acc_t     ATAN_I = atan_q24(IDX);

    logic                    valid_reg;
    logic signed [CW-1:0]    cx_reg, cx_next;
    logic signed [CW-1:0]    cy_reg, cy_next;
    angle_acc_t              z_reg, z_next;
    logic                    zero_reg;
    logic [RW-1:0]           rem_reg, rem_next;
    logic [RW-1:0]           root_reg, root_next;
    logic signed [ROT_W-1:0] rot_reg;
    logic signed [W-1:0]     x_reg, y_reg;
    logic [RW-1:0]           trial;

    assign trial = in_root + SQ_BIT;

    always_comb begin
        cx_next = in_cx;
        cy_next = in_cy;
        z_next  = in_z;
        if (DO_ROT) begin
            // Rotate toward the x axis; the sign of y picks the direction.
            if (!in_cy[CW-1]) begin
                cx_next = in_cx + (in_cy >>> IDX);
                cy_next = in_cy - (in_cx >>> IDX);
                z_next  = in_z + ATAN_I;
            end else begin
                cx_next = in_cx - (in_cy >>> IDX);
                cy_next = in_cy + (in_cx >>> IDX);
                z_next  = in_z - ATAN_I;
            end
        end

        rem_next  = in_rem;
        root_next = in_root;
        if (DO_SQRT) begin
            if (in_rem >= trial) begin
                rem_next  = in_rem - trial;
                root_next = (in_root >> 1) + SQ_BIT;
            end else begin
                root_next = in_root >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            z_reg    <= z_next;
            zero_reg <= in_zero;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rot_reg  <= in_rot;
            x_reg    <= in_x;
            y_reg    <= in_y;
        end
    end

    assign out_valid = valid_reg;
    assign out_cx    = cx_reg;
    assign out_cy    = cy_reg;
    assign out_z     = z_reg;
    assign out_zero  = zero_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rot   = rot_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

// ===== rtl/c2p_finish.sv =====
// Tail of the unit: scales the rotation offset, rounds the root, then adds and
// rounds the angle into the output register. Depends on c2p_pkg.
module c2p_finish import c2p_pkg::*; #(
    parameter int W = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  angle_acc_t                 in_z,
    input  logic                       in_zero,
    input  logic [2*W:0]               in_rem,
    input  logic [2*W:0]               in_root,
    input  logic signed [ROT_W-1:0]    in_rot,
    input  logic signed [W-1:0]        in_x,
    input  logic signed [W-1:0]        in_y,
    output logic                       out_valid,
    output logic signed [ANGLE_W-1:0]  out_angle,
    output logic [W-1:0]               out_radius,
    output logic signed [W-1:0]        out_x,
    output logic signed [W-1:0]        out_y
);
    localparam int RW = 2 * W + 1;

    logic                        f_valid_reg;
    angle_acc_t                  f_z_reg;
    logic signed [PROD_W-1:0]    f_prod_reg, f_prod_next;
    logic [W-1:0]                f_radius_reg;
    logic [RW-1:0]               radius_next;
    logic signed [W-1:0]         f_x_reg, f_y_reg;

    logic                        o_valid_reg;
    logic signed [ANGLE_W-1:0]   o_angle_reg;
    logic [W-1:0]                o_radius_reg;
    logic signed [W-1:0]         o_x_reg, o_y_reg;
    logic signed [TOTAL_W-1:0]   total;

    assign f_prod_next = PROD_W'(in_rot) * PROD_W'(ROT_UNIT_Q32);
    // Rounding up only when the remainder exceeds the root rounds to nearest.
    assign radius_next = in_root + RW'(in_rem > in_root);

    assign total = (TOTAL_W'(f_z_reg) <<< 8) + TOTAL_W'(f_prod_reg)
                 + (TOTAL_W'(1) <<< (ROUND_SH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= in_valid;
            o_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_z_reg      <= in_zero ? '0 : in_z;
            f_prod_reg   <= f_prod_next;
            f_radius_reg <= radius_next[W-1:0];
            f_x_reg      <= in_x;
            f_y_reg      <= in_y;
            o_angle_reg  <= total[ANGLE_W+ROUND_SH-1:ROUND_SH];
            o_radius_reg <= f_radius_reg;
            o_x_reg      <= f_x_reg;
            o_y_reg      <= f_y_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_angle  = o_angle_reg;
    assign out_radius = o_radius_reg;
    assign out_x      = o_x_reg;
    assign out_y      = o_y_reg;

endmodule

// ===== rtl/cartesian_to_polar_rotated_unit.sv =====
// Path from request to result: one entry stage, one cell per chain position and two
// tail stages, all registered.
// Throughput: one request per cycle; the whole chain advances together and holds
// only while a result sits in the output register and m_ready is low.
// Reset: aresetn is synchronous and active low; it clears every valid flag, so
// the pipeline comes out of reset empty and ready.
module cartesian_to_polar_rotated_unit import c2p_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_x_in,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_y_in,
    input  logic signed [ROT_W-1:0]           s_rotation,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ANGLE_W-1:0]         m_angle,
    output logic [SAMPLE_WIDTH-1:0]           m_magnitude,
    output logic signed [SAMPLE_WIDTH-1:0]    m_x_out,
    output logic signed [SAMPLE_WIDTH-1:0]    m_y_out
);
    localparam int W     = SAMPLE_WIDTH;
    localparam int CW    = W + 19;
    localparam int RW    = 2 * W + 1;
    localparam int NCELL = (CORDIC_STAGES > W) ? CORDIC_STAGES : W;

    logic                    adv;
    logic                    valid_w [NCELL+1];
    logic signed [CW-1:0]    cx_w    [NCELL+1];
    logic signed [CW-1:0]    cy_w    [NCELL+1];
    angle_acc_t              z_w     [NCELL+1];
    logic                    zero_w  [NCELL+1];
    logic [RW-1:0]           rem_w   [NCELL+1];
    logic [RW-1:0]           root_w  [NCELL+1];
    logic signed [ROT_W-1:0] rot_w   [NCELL+1];
    logic signed [W-1:0]     x_w     [NCELL+1];
    logic signed [W-1:0]     y_w     [NCELL+1];

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    assign root_w[0] = '0;

    c2p_prep #(.W(W)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_x      (s_x_in),
        .in_y      (s_y_in),
        .in_rot    (s_rotation),
        .out_valid (valid_w[0]),
        .out_cx    (cx_w[0]),
        .out_cy    (cy_w[0]),
        .out_z     (z_w[0]),
        .out_zero  (zero_w[0]),
        .out_rem   (rem_w[0]),
        .out_rot   (rot_w[0]),
        .out_x     (x_w[0]),
        .out_y     (y_w[0])
    );

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        c2p_cell #(.IDX(i), .STAGES(CORDIC_STAGES), .W(W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (valid_w[i]),
            .in_cx     (cx_w[i]),
            .in_cy     (cy_w[i]),
            .in_z      (z_w[i]),
            .in_zero   (zero_w[i]),
            .in_rem    (rem_w[i]),
            .in_root   (root_w[i]),
            .in_rot    (rot_w[i]),
            .in_x      (x_w[i]),
            .in_y      (y_w[i]),
            .out_valid (valid_w[i+1]),
            .out_cx    (cx_w[i+1]),
            .out_cy    (cy_w[i+1]),
            .out_z     (z_w[i+1]),
            .out_zero  (zero_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_root  (root_w[i+1]),
            .out_rot   (rot_w[i+1]),
            .out_x     (x_w[i+1]),
            .out_y     (y_w[i+1])
        );
    end

    c2p_finish #(.W(W)) u_finish (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (valid_w[NCELL]),
        .in_z       (z_w[NCELL]),
        .in_zero    (zero_w[NCELL]),
        .in_rem     (rem_w[NCELL]),
        .in_root    (root_w[NCELL]),
        .in_rot     (rot_w[NCELL]),
        .in_x       (x_w[NCELL]),
        .in_y       (y_w[NCELL]),
        .out_valid  (m_valid),
        .out_angle  (m_angle),
        .out_radius (m_magnitude),
        .out_x      (m_x_out),
        .out_y      (m_y_out)
    );

`ifndef SYNTHESIS
    // The chain only holds back a request while a result is blocked at the output.
    a_stall_only_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a blocked result");

    // The origin has zero magnitude.
    a_origin_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_x_out == '0 && m_y_out == '0) |-> (m_magnitude == '0))
        else $error("nonzero radius at the origin");

    // On the positive x axis the magnitude is x itself.
    a_axis_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_y_out == '0 && !m_x_out[W-1]) |-> (m_magnitude == W'(m_x_out)))
        else $error("radius differs from x on the positive x axis");
`endif

endmodule
